// File: src/leeb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leeb_pkg
// Shared constants and types for the line editor with echo.
// ----------------------------------------------------------------------------
package leeb_pkg;

    // control characters
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_BS = 8'h08;
    localparam logic [7:0] CH_SP = 8'h20;

    // default line length
    localparam int LINE_CHARS_DEF = 32;

    // one byte pushed into the output queue
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } t_push;

    // output queue status seen by the sequencer
    typedef struct packed {
        logic [1:0] cnt;
        logic       pop;
    } t_fifo_stat;

endpackage

// File: src/leeb_line_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leeb_line_ram
// Line store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module leeb_line_ram #(
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/leeb_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leeb_out_fifo
// Two-entry output queue that decouples the sequencer from the receiver.
// ----------------------------------------------------------------------------
module leeb_out_fifo
    import leeb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_push      i_push,
    output t_fifo_stat o_stat,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_data,
    output logic       o_last
);

    logic [8:0] r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       pop;

    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && !i_stall;
    assign o_data  = r_mem[r_rp][8:1];
    assign o_last  = r_mem[r_rp][0];

    assign o_stat.cnt = r_cnt;
    assign o_stat.pop = pop;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wp] <= {i_push.data, i_push.last};
        end
    end

    // pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push.valid) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push.valid} - {1'b0, pop};
        end
    end

    // checks
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push.valid && r_cnt == 2'd2 && !pop))
        else $error("output queue overflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output queue count out of range");
    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !i_push.valid |=> r_cnt == $past(r_cnt) - 2'd1)
        else $error("output queue count did not drop on a transaction");

endmodule

// File: src/leeb_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leeb_seq
// Sequencer: decodes each received byte, updates the line store and fill
// count, and feeds echo and replay bytes into the output queue.
// ----------------------------------------------------------------------------
module leeb_seq
    import leeb_pkg::*;
#(
    parameter int LINE_CHARS = LINE_CHARS_DEF,
    localparam int AW = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1,
    localparam int CW = $clog2(LINE_CHARS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rx_valid,
    output logic          o_rx_stall,
    input  logic [7:0]    i_rx_byte,
    input  t_fifo_stat    i_stat,
    output t_push         o_push,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output logic [7:0]    o_wr_data,
    output logic          o_rd_en,
    output logic [AW-1:0] o_rd_addr,
    input  logic [7:0]    i_rd_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ECHO,
        S_CR_HEAD,
        S_REPLAY,
        S_CR_TAIL,
        S_BS1,
        S_BS2,
        S_BS3
    } t_state;

    localparam logic [CW-1:0] LC = CW'(LINE_CHARS);

    t_state        r_state, n_state;
    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_idx, n_idx;
    logic [7:0]    r_char, n_char;
    logic          r_pend;
    logic          accept;
    logic [2:0]    occ;
    logic          space;
    t_push         fsm_push;

    assign o_rx_stall = (r_state != S_IDLE);
    assign accept     = i_rx_valid && (r_state == S_IDLE);

    // queue entries committed or in flight after this cycle's pop
    assign occ   = {1'b0, i_stat.cnt} - {2'b0, i_stat.pop} + {2'b0, r_pend};
    assign space = (occ <= 3'd1);

    // store write happens only on acceptance; replay reads come later, so
    // the same entry is never written and read in overlapping cycles
    assign o_wr_addr = r_fill[AW-1:0];
    assign o_wr_data = i_rx_byte;
    assign o_rd_addr = r_idx[AW-1:0];

    // queue input: replay data from the store or a byte from the sequencer
    assign o_push.valid = r_pend || fsm_push.valid;
    assign o_push.data  = r_pend ? i_rd_data : fsm_push.data;
    assign o_push.last  = r_pend ? 1'b0 : fsm_push.last;

    // next state and datapath control
    always_comb begin
        n_state        = r_state;
        n_fill         = r_fill;
        n_idx          = r_idx;
        n_char         = r_char;
        o_wr_en        = 1'b0;
        o_rd_en        = 1'b0;
        fsm_push.valid = 1'b0;
        fsm_push.data  = CH_CR;
        fsm_push.last  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_char = i_rx_byte;
                    n_idx  = '0;
                    if (i_rx_byte == CH_CR) begin
                        n_state = S_CR_HEAD;
                    end else if (i_rx_byte == CH_BS) begin
                        n_state = S_BS1;
                    end else if (r_fill < LC) begin
                        o_wr_en = 1'b1;
                        n_fill  = r_fill + 1'b1;
                        n_state = S_ECHO;
                    end
                end
            end
            S_ECHO: begin
                if (space) begin
                    fsm_push.valid = 1'b1;
                    fsm_push.data  = r_char;
                    fsm_push.last  = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_CR_HEAD: begin
                if (space) begin
                    fsm_push.valid = 1'b1;
                    n_state        = S_REPLAY;
                end
            end
            S_REPLAY: begin
                if (r_idx == r_fill) begin
                    n_state = S_CR_TAIL;
                end else if (space) begin
                    o_rd_en = 1'b1;
                    n_idx   = r_idx + 1'b1;
                end
            end
            S_CR_TAIL: begin
                if (space && !r_pend) begin
                    fsm_push.valid = 1'b1;
                    fsm_push.last  = 1'b1;
                    n_fill         = '0;
                    n_state        = S_IDLE;
                end
            end
            S_BS1: begin
                if (space) begin
                    fsm_push.valid = 1'b1;
                    fsm_push.data  = CH_BS;
                    n_state        = S_BS2;
                end
            end
            S_BS2: begin
                if (space) begin
                    fsm_push.valid = 1'b1;
                    fsm_push.data  = CH_SP;
                    n_state        = S_BS3;
                end
            end
            S_BS3: begin
                if (space) begin
                    fsm_push.valid = 1'b1;
                    fsm_push.data  = CH_BS;
                    fsm_push.last  = 1'b1;
                    if (r_fill != '0) begin
                        n_fill = r_fill - 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_idx   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_idx   <= n_idx;
            r_pend  <= o_rd_en;
        end
        r_char <= n_char;
    end

    // checks
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= LC)
        else $error("fill count beyond line length");
    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rd_en |-> (r_state == S_REPLAY) && (r_idx < r_fill))
        else $error("store read outside the filled line");
    a_no_push_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pend && fsm_push.valid))
        else $error("replay data and sequencer byte pushed together");
    a_tail_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CR_TAIL) && (n_state == S_IDLE) |=> r_fill == '0)
        else $error("line not emptied after carriage return");

endmodule

// File: src/line_edit_echo_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_edit_echo_buffer
// Line editor with echo: stores received bytes, handles backspace and
// carriage return, and sends echo and replayed line bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_rx_valid / o_rx_stall / i_rx_byte) carries one
//   received byte per transaction. Output channel (o_tx_valid / i_tx_stall /
//   o_tx_byte / o_last_of_run) carries one byte to transmit per
//   transaction; o_last_of_run marks the final byte caused by an input.
//   An ordinary byte is stored and echoed (dropped silently if the line is
//   full). Backspace sends 08 20 08 and steps the fill count back, never
//   below zero. Carriage return sends 0D, the stored line, 0D and empties it.
//   The sequencer registers the accepted input in its state and then pushes
//   the first result into the output queue. The block takes one input at a
//   time. The replay moves one stored byte per cycle while the output
//   queue has space, through the single read port of the line store, its
//   data landing in a two-entry output queue.
//   Reset clears the fill count, sequencer and output queue; the store itself
//   is not cleared. A receiver stall holds the queue head and pauses the
//   sequencer once the queue is full; o_rx_stall stays high until the
//   current input's results are all queued.
// ----------------------------------------------------------------------------
module line_edit_echo_buffer
    import leeb_pkg::*;
#(
    parameter int LINE_CHARS = LINE_CHARS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_tx_valid,
    input  logic       i_tx_stall,
    output logic [7:0] o_tx_byte,
    output logic       o_last_of_run
);

    localparam int AW = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;

    t_push         push;
    t_fifo_stat    stat;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    // sequencer
    leeb_seq #(
        .LINE_CHARS(LINE_CHARS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_stall (o_rx_stall),
        .i_rx_byte  (i_rx_byte),
        .i_stat     (stat),
        .o_push     (push),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data)
    );

    // line store
    leeb_line_ram #(
        .DEPTH(LINE_CHARS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // output queue
    leeb_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_stat  (stat),
        .o_valid (o_tx_valid),
        .i_stall (i_tx_stall),
        .o_data  (o_tx_byte),
        .o_last  (o_last_of_run)
    );

endmodule
